// ===== rtl/core/emhm_pkg.sv =====
// Package for the extended memory handle manager.
// Holds function codes, error codes, datapath ops and controller/datapath structs.
// No dependencies.
package emhm_pkg;

  localparam int unsigned HANDLE_SLOTS_DEF = 64;
  localparam int unsigned RESERVED_KB_DEF  = 64;

  localparam logic [15:0] POOL_END_RST = 16'h8000;
  localparam logic [15:0] XMS_VERSION  = 16'h0300;
  localparam logic [31:0] LIN_BASE     = 32'h0010_0000;
  localparam logic [15:0] AX_OK        = 16'h0001;

  localparam logic [7:0] FN_VERSION   = 8'h00;
  localparam logic [7:0] FN_HMA_REQ   = 8'h01;
  localparam logic [7:0] FN_HMA_REL   = 8'h02;
  localparam logic [7:0] FN_A20_FIRST = 8'h03;
  localparam logic [7:0] FN_A20_LAST  = 8'h07;
  localparam logic [7:0] FN_QUERY     = 8'h08;
  localparam logic [7:0] FN_ALLOC     = 8'h09;
  localparam logic [7:0] FN_FREE      = 8'h0A;
  localparam logic [7:0] FN_LOCK      = 8'h0C;
  localparam logic [7:0] FN_UNLOCK    = 8'h0D;
  localparam logic [7:0] FN_INFO      = 8'h0E;
  localparam logic [7:0] FN_REALLOC   = 8'h0F;
  localparam logic [7:0] FN_UMB_REQ   = 8'h10;
  localparam logic [7:0] FN_UMB_REL   = 8'h11;

  typedef enum logic [3:0] {
    ERR_NONE,
    ERR_NOTIMPL,
    ERR_NOHMA,
    ERR_NOMEM,
    ERR_NOHANDLE,
    ERR_BADHANDLE,
    ERR_NOTLOCKED,
    ERR_LOCKED,
    ERR_NOUMB,
    ERR_BADUMB
  } err_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_HLATCH,
    OP_SUM_CLR,
    OP_SUM_ACC,
    OP_CAND0,
    OP_CAND,
    OP_QSTEP,
    OP_QBEST,
    OP_GAP_INIT,
    OP_GSTEP,
    FIN_SIMPLE,
    FIN_ERR,
    FIN_QRY,
    FIN_ALLOC,
    FIN_FREE,
    FIN_LOCK,
    FIN_UNLOCK,
    FIN_INFO,
    FIN_SHRINK,
    FIN_REALLOC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_h;
    err_t   err;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] func;
    logic       has_free;
    logic       h_ok;
    logic       locked;
    logic       shrink;
    logic       gap_fail;
    logic       ovl;
    logic       in_blk;
    logic       s_bad;
    logic       vld;
  } dp_stat_t;

endpackage

// ===== rtl/core/emhm_ifs.sv =====
// Channel interfaces of the extended memory handle manager.
// Depends on nothing; request, response and configuration channels.
interface emhm_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  func;
  logic [15:0] dx_word;
  logic [15:0] bx_word;
  modport source (output valid, func, dx_word, bx_word, input ready);
  modport sink (input valid, func, dx_word, bx_word, output ready);
endinterface

interface emhm_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_ax;
  logic [15:0] out_bx;
  logic [15:0] out_dx;
  logic [3:0]  error_code;
  modport source (output valid, out_ax, out_bx, out_dx, error_code, input ready);
  modport sink (input valid, out_ax, out_bx, out_dx, error_code, output ready);
endinterface

interface emhm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] pool_end_kb;
  modport source (output valid, pool_end_kb, input ready);
  modport sink (input valid, pool_end_kb, output ready);
endinterface

// ===== rtl/core/emhm_dp.sv =====
// Datapath: handle table memories, valid bits, scan registers and result registers.
// Depends on emhm_pkg; driven by emhm_ctl through dp_cmd_t.
module emhm_dp
  import emhm_pkg::*;
#(
  parameter int unsigned HANDLE_SLOTS = HANDLE_SLOTS_DEF,
  parameter int unsigned RESERVED_KB  = RESERVED_KB_DEF,
  localparam int unsigned HW = $clog2(HANDLE_SLOTS)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     func_i,
  input  logic [15:0]    dx_i,
  input  logic [15:0]    bx_i,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  dp_cmd_t        cmd,
  input  logic [HW-1:0]  addr,
  output dp_stat_t       st,
  output logic [15:0]    ax_o,
  output logic [15:0]    bx_o,
  output logic [15:0]    dx_o,
  output logic [3:0]     err_o
);

  localparam logic [16:0] RES17 = 17'(RESERVED_KB);
  localparam int unsigned UW    = 16 + HW;

  logic [7:0]              func_r;
  logic [15:0]             req_dx_r, req_bx_r, pool_end_r;
  logic [HANDLE_SLOTS-1:0] valid_r;
  logic [31:0]             blk_mem [HANDLE_SLOTS];
  logic [15:0]             lock_mem [HANDLE_SLOTS];
  logic [31:0]             blk_q;
  logic [15:0]             lock_q;
  logic [15:0]             hoff_r, hsize_r, hlock_r;
  logic [16:0]             cur_r, s_r, nx_r, best_r;
  logic [UW-1:0]           used_r;
  logic [7:0]              nfree_r;
  logic [15:0]             rax_r, rbx_r, rdx_r;
  err_t                    rerr_r;
  logic [15:0]             rax_nxt, rbx_nxt, rdx_nxt;
  err_t                    rerr_nxt;

  logic [HW-1:0] hsel, freeh, excl, rd_addr, wa;
  logic          has_free, vld;
  logic [15:0]   gsize, ea, esz;
  logic [16:0]   eb, span;
  logic [17:0]   cur_end;
  logic [UW-1:0] span_w;
  logic [15:0]   total;
  logic [31:0]   lin;
  logic [7:0]    lc8;
  logic          blk_we, lock_we;
  logic [31:0]   blk_wd;
  logic [15:0]   lock_wd;

  assign hsel    = req_dx_r[HW-1:0];
  assign rd_addr = cmd.sel_h ? hsel : addr;
  assign ea      = blk_q[31:16];
  assign esz     = blk_q[15:0];
  assign eb      = {1'b0, ea} + {1'b0, esz};
  assign vld     = valid_r[addr];
  assign gsize   = (func_r == FN_ALLOC) ? req_dx_r : req_bx_r;
  assign excl    = (func_r == FN_REALLOC) ? hsel : '0;
  assign cur_end = {1'b0, cur_r} + {2'b00, gsize};
  assign span    = (pool_end_r > 16'(RESERVED_KB)) ?
                   ({1'b0, pool_end_r} - RES17) : 17'd0;
  assign span_w  = UW'(span);
  assign total   = (span_w > used_r) ? 16'(span_w - used_r) : 16'd0;
  assign lin     = LIN_BASE + {6'd0, hoff_r, 10'd0};
  assign lc8     = (hlock_r > 16'd255) ? 8'hFF : hlock_r[7:0];
  assign wa      = (cmd.op == FIN_ALLOC) ? freeh : hsel;

  always_comb begin
    freeh    = '0;
    has_free = 1'b0;
    for (int i = HANDLE_SLOTS - 1; i >= 1; i--) begin
      if (!valid_r[i]) begin
        freeh    = HW'(i);
        has_free = 1'b1;
      end
    end
  end

  always_comb begin
    st.func     = func_r;
    st.has_free = has_free;
    st.h_ok     = (req_dx_r != 16'd0) && (req_dx_r < 16'(HANDLE_SLOTS)) && valid_r[hsel];
    st.locked   = hlock_r != 16'd0;
    st.shrink   = req_bx_r <= hsize_r;
    st.gap_fail = cur_end > {2'b00, pool_end_r};
    st.ovl      = vld && (addr != excl) && (cur_r < eb) && (cur_end > {2'b00, ea});
    st.in_blk   = vld && (s_r >= {1'b0, ea}) && (s_r < eb);
    st.s_bad    = (s_r < RES17) || (s_r >= {1'b0, pool_end_r});
    st.vld      = vld;
  end

  always_comb begin
    blk_we  = 1'b0;
    blk_wd  = {hoff_r, req_bx_r};
    lock_we = 1'b0;
    lock_wd = 16'd0;
    case (cmd.op)
      FIN_ALLOC: begin
        blk_we  = 1'b1;
        blk_wd  = {cur_r[15:0], req_dx_r};
        lock_we = 1'b1;
      end
      FIN_SHRINK: begin
        blk_we = 1'b1;
      end
      FIN_REALLOC: begin
        blk_we = 1'b1;
        blk_wd = {cur_r[15:0], req_bx_r};
      end
      FIN_LOCK: begin
        lock_we = 1'b1;
        lock_wd = (hlock_r == 16'hFFFF) ? hlock_r : hlock_r + 16'd1;
      end
      FIN_UNLOCK: begin
        lock_we = 1'b1;
        lock_wd = hlock_r - 16'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rax_nxt  = 16'd0;
    rbx_nxt  = 16'd0;
    rdx_nxt  = 16'd0;
    rerr_nxt = ERR_NONE;
    case (cmd.op)
      FIN_SIMPLE: begin
        case (func_r) inside
          FN_VERSION: begin
            rax_nxt = XMS_VERSION;
            rbx_nxt = XMS_VERSION;
          end
          FN_HMA_REQ, FN_HMA_REL: rerr_nxt = ERR_NOHMA;
          [FN_A20_FIRST:FN_A20_LAST]: rax_nxt = AX_OK;
          FN_UMB_REQ: rerr_nxt = ERR_NOUMB;
          FN_UMB_REL: rerr_nxt = ERR_BADUMB;
          default: rerr_nxt = ERR_NOTIMPL;
        endcase
      end
      FIN_ERR: rerr_nxt = cmd.err;
      FIN_QRY: begin
        rax_nxt = best_r[15:0];
        rdx_nxt = total;
      end
      FIN_ALLOC: begin
        rax_nxt = AX_OK;
        rdx_nxt = 16'(freeh);
      end
      FIN_LOCK: begin
        rax_nxt = AX_OK;
        rbx_nxt = lin[15:0];
        rdx_nxt = lin[31:16];
      end
      FIN_INFO: begin
        rax_nxt = AX_OK;
        rbx_nxt = {lc8, nfree_r};
        rdx_nxt = hsize_r;
      end
      FIN_FREE, FIN_UNLOCK, FIN_SHRINK, FIN_REALLOC: rax_nxt = AX_OK;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[wa] <= blk_wd;
    end
    if (lock_we) begin
      lock_mem[wa] <= lock_wd;
    end
    blk_q  <= blk_mem[rd_addr];
    lock_q <= lock_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      pool_end_r <= POOL_END_RST;
    end else begin
      if (cfg_we) begin
        pool_end_r <= cfg_data;
      end
      if (cmd.op == FIN_ALLOC) begin
        valid_r[freeh] <= 1'b1;
      end else if (cmd.op == FIN_FREE) begin
        valid_r[hsel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        func_r   <= func_i;
        req_dx_r <= dx_i;
        req_bx_r <= bx_i;
      end
      OP_HLATCH: begin
        hoff_r  <= ea;
        hsize_r <= esz;
        hlock_r <= lock_q;
      end
      OP_SUM_CLR: begin
        used_r  <= '0;
        nfree_r <= '0;
        best_r  <= '0;
      end
      OP_SUM_ACC: begin
        if (vld) begin
          used_r <= used_r + UW'(esz);
        end else begin
          nfree_r <= nfree_r + 8'd1;
        end
      end
      OP_CAND0: begin
        s_r  <= RES17;
        nx_r <= {1'b0, pool_end_r};
      end
      OP_CAND: begin
        s_r  <= eb;
        nx_r <= {1'b0, pool_end_r};
      end
      OP_QSTEP: begin
        if (vld && ({1'b0, ea} >= s_r) && ({1'b0, ea} < nx_r)) begin
          nx_r <= {1'b0, ea};
        end
      end
      OP_QBEST: begin
        if ((nx_r - s_r) > best_r) begin
          best_r <= nx_r - s_r;
        end
      end
      OP_GAP_INIT: begin
        cur_r <= RES17;
      end
      OP_GSTEP: begin
        if (st.ovl) begin
          cur_r <= eb;
        end
      end
      FIN_SIMPLE, FIN_ERR, FIN_QRY, FIN_ALLOC, FIN_FREE, FIN_LOCK,
      FIN_UNLOCK, FIN_INFO, FIN_SHRINK, FIN_REALLOC: begin
        rax_r  <= rax_nxt;
        rbx_r  <= rbx_nxt;
        rdx_r  <= rdx_nxt;
        rerr_r <= rerr_nxt;
      end
      default: begin
      end
    endcase
  end

  assign ax_o  = rax_r;
  assign bx_o  = rbx_r;
  assign dx_o  = rdx_r;
  assign err_o = rerr_r;

endmodule

// ===== rtl/core/emhm_ctl.sv =====
// Controller: sequences table scans and the result beat of each request.
// Depends on emhm_pkg; drives emhm_dp through dp_cmd_t and reads dp_stat_t.
module emhm_ctl
  import emhm_pkg::*;
#(
  parameter int unsigned HANDLE_SLOTS = HANDLE_SLOTS_DEF,
  localparam int unsigned HW = $clog2(HANDLE_SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dp_stat_t      st,
  output dp_cmd_t       cmd,
  output logic [HW-1:0] addr
);

  localparam logic [HW-1:0] LAST  = HW'(HANDLE_SLOTS - 1);
  localparam logic [HW-1:0] FIRST = HW'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_HLAT, S_HACT, S_SUM_RD, S_SUM_EV, S_QC0, S_QC_SEL,
    S_QC_EV, S_QCHK, S_QS_RD, S_QS_EV, S_QEND, S_GP_PASS, S_GP_RD, S_GP_EV, S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [HW-1:0] idx_r, idx_nxt, cidx_r, cidx_nxt;
  dp_op_t        fin_op_r, fin_op_nxt;
  err_t          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          adv_cand;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cidx_nxt      = cidx_r;
    fin_op_nxt    = fin_op_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.sel_h     = 1'b0;
    cmd.err       = err_r;
    addr          = idx_r;
    adv_cand      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.sel_h = 1'b1;
        idx_nxt   = FIRST;
        state_nxt = S_FIN;
        case (st.func) inside
          FN_QUERY: begin
            cmd.op    = OP_SUM_CLR;
            state_nxt = S_SUM_RD;
          end
          FN_ALLOC: begin
            if (!st.has_free) begin
              fin_op_nxt = FIN_ERR;
              err_nxt    = ERR_NOHANDLE;
            end else begin
              cmd.op    = OP_GAP_INIT;
              state_nxt = S_GP_PASS;
            end
          end
          FN_FREE, FN_LOCK, FN_UNLOCK, FN_INFO, FN_REALLOC: begin
            if (!st.h_ok) begin
              fin_op_nxt = FIN_ERR;
              err_nxt    = ERR_BADHANDLE;
            end else begin
              state_nxt = S_HLAT;
            end
          end
          default: fin_op_nxt = FIN_SIMPLE;
        endcase
      end
      S_HLAT: begin
        cmd.op    = OP_HLATCH;
        state_nxt = S_HACT;
      end
      S_HACT: begin
        state_nxt = S_FIN;
        case (st.func)
          FN_FREE: begin
            fin_op_nxt = st.locked ? FIN_ERR : FIN_FREE;
            err_nxt    = ERR_LOCKED;
          end
          FN_LOCK: fin_op_nxt = FIN_LOCK;
          FN_UNLOCK: begin
            fin_op_nxt = st.locked ? FIN_UNLOCK : FIN_ERR;
            err_nxt    = ERR_NOTLOCKED;
          end
          FN_INFO: begin
            cmd.op    = OP_SUM_CLR;
            state_nxt = S_SUM_RD;
          end
          default: begin
            if (st.locked) begin
              fin_op_nxt = FIN_ERR;
              err_nxt    = ERR_LOCKED;
            end else if (st.shrink) begin
              fin_op_nxt = FIN_SHRINK;
            end else begin
              cmd.op    = OP_GAP_INIT;
              state_nxt = S_GP_PASS;
            end
          end
        endcase
      end
      S_SUM_RD: state_nxt = S_SUM_EV;
      S_SUM_EV: begin
        cmd.op = OP_SUM_ACC;
        if (idx_r == LAST) begin
          if (st.func == FN_INFO) begin
            fin_op_nxt = FIN_INFO;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_QC0;
          end
        end else begin
          idx_nxt   = idx_r + FIRST;
          state_nxt = S_SUM_RD;
        end
      end
      S_QC0: begin
        cmd.op    = OP_CAND0;
        cidx_nxt  = '0;
        state_nxt = S_QCHK;
      end
      S_QC_SEL: begin
        addr = cidx_r;
        if (st.vld) begin
          state_nxt = S_QC_EV;
        end else begin
          adv_cand = 1'b1;
        end
      end
      S_QC_EV: begin
        cmd.op    = OP_CAND;
        state_nxt = S_QCHK;
      end
      S_QCHK: begin
        if (st.s_bad) begin
          adv_cand = 1'b1;
        end else begin
          idx_nxt   = FIRST;
          state_nxt = S_QS_RD;
        end
      end
      S_QS_RD: state_nxt = S_QS_EV;
      S_QS_EV: begin
        cmd.op = OP_QSTEP;
        if (st.in_blk) begin
          adv_cand = 1'b1;
        end else if (idx_r == LAST) begin
          state_nxt = S_QEND;
        end else begin
          idx_nxt   = idx_r + FIRST;
          state_nxt = S_QS_RD;
        end
      end
      S_QEND: begin
        cmd.op   = OP_QBEST;
        adv_cand = 1'b1;
      end
      S_GP_PASS: begin
        idx_nxt = FIRST;
        if (st.gap_fail) begin
          fin_op_nxt = FIN_ERR;
          err_nxt    = ERR_NOMEM;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_GP_RD;
        end
      end
      S_GP_RD: state_nxt = S_GP_EV;
      S_GP_EV: begin
        cmd.op = OP_GSTEP;
        if (st.ovl) begin
          state_nxt = S_GP_PASS;
        end else if (idx_r == LAST) begin
          fin_op_nxt = (st.func == FN_ALLOC) ? FIN_ALLOC : FIN_REALLOC;
          state_nxt  = S_FIN;
        end else begin
          idx_nxt   = idx_r + FIRST;
          state_nxt = S_GP_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = fin_op_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (adv_cand) begin
      if (cidx_r == LAST) begin
        fin_op_nxt = FIN_QRY;
        state_nxt  = S_FIN;
      end else begin
        cidx_nxt  = cidx_r + FIRST;
        state_nxt = S_QC_SEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= FIRST;
      cidx_r      <= '0;
      fin_op_r    <= FIN_SIMPLE;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cidx_r      <= cidx_nxt;
      fin_op_r    <= fin_op_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/extended_memory_handle_manager_top.sv =====
// Channel   | dir | beat contents
// in_ch     | in  | func, dx_word, bx_word
// out_ch    | out | out_ax, out_bx, out_dx, error_code
// cfg_ch    | in  | pool_end_kb, always ready
//
// One request at a time. Simple functions go from decode to the result beat;
// handle functions first latch the handle's table entry. Info adds a table sum.
// Allocate and growing reallocate run up to HANDLE_SLOTS first-fit passes; the
// free query runs the same sum and up to HANDLE_SLOTS candidate scans. Each step
// reads one table entry through the single table read port.
// Reset is synchronous and clears the valid bits at once; no clearing pass.
// A finished beat waits in the output register while the next request is
// accepted; that request holds before its result until the register frees.
// Depends on emhm_pkg, emhm_ifs, emhm_ctl and emhm_dp.
module extended_memory_handle_manager_top
  import emhm_pkg::*;
#(
  parameter int unsigned HANDLE_SLOTS = HANDLE_SLOTS_DEF,
  parameter int unsigned RESERVED_KB  = RESERVED_KB_DEF
) (
  input logic       clk,
  input logic       rst_n,
  emhm_req_if.sink  in_ch,
  emhm_rsp_if.source out_ch,
  emhm_cfg_if.sink  cfg_ch
);

  localparam int unsigned HW = $clog2(HANDLE_SLOTS);

  dp_cmd_t       cmd;
  dp_stat_t      st;
  logic [HW-1:0] addr;

  assign cfg_ch.ready = 1'b1;

  emhm_ctl #(
    .HANDLE_SLOTS(HANDLE_SLOTS)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd),
    .addr      (addr)
  );

  emhm_dp #(
    .HANDLE_SLOTS(HANDLE_SLOTS),
    .RESERVED_KB (RESERVED_KB)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .func_i   (in_ch.func),
    .dx_i     (in_ch.dx_word),
    .bx_i     (in_ch.bx_word),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.pool_end_kb),
    .cmd      (cmd),
    .addr     (addr),
    .st       (st),
    .ax_o     (out_ch.out_ax),
    .bx_o     (out_ch.out_bx),
    .dx_o     (out_ch.out_dx),
    .err_o    (out_ch.error_code)
  );

endmodule

// ===== rtl/core/emhm_chk.sv =====
// Port checker for the extended memory handle manager, bound to the top level.
// Depends on the top level's channel ports only.
module emhm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_ax,
  input logic [15:0] out_bx,
  input logic [15:0] out_dx,
  input logic [3:0]  error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ax) && $stable(out_bx)
      && $stable(out_dx) && $stable(error_code))
    else $error("result beat changed while stalled");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> error_code <= 4'd9)
    else $error("error code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code != 4'd0 |-> out_ax == 16'd0 && out_bx == 16'd0
      && out_dx == 16'd0)
    else $error("failed request carries nonzero registers");

endmodule

bind extended_memory_handle_manager_top emhm_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_ax     (out_ch.out_ax),
  .out_bx     (out_ch.out_bx),
  .out_dx     (out_ch.out_dx),
  .error_code (out_ch.error_code)
);

// ===== tb/sv/extended_memory_handle_manager_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for extended_memory_handle_manager_top: directed table, then random requests,
// each checked against its row or an in-bench table model. Depends on emhm_pkg and emhm_ifs.
module extended_memory_handle_manager_top_test;
  import emhm_pkg::*;

  localparam int SLOTS = 64;
  localparam int RSV = 64;
  localparam int LIMIT = 6000000;
  localparam logic [7:0] FN_MOVE = 8'h0B;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] bx;
    logic [15:0] dx;
    logic [3:0]  err;
  } rsp_t;

  typedef struct {
    logic [7:0]  func;
    logic [15:0] dx;
    logic [15:0] bx;
    bit          typed;
    rsp_t        rsp;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  emhm_req_if in_ch();
  emhm_rsp_if out_ch();
  emhm_cfg_if cfg_ch();

  extended_memory_handle_manager_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  int unsigned pool_end;
  bit          blk_valid[SLOTS];
  int unsigned blk_locks[SLOTS];
  int unsigned blk_off[SLOTS];
  int unsigned blk_size[SLOTS];

  rsp_t pending_rsp[$];
  int   mismatches = 0;
  int   beats_in = 0;
  int   beats_out = 0;
  int   cycles = 0;
  bit   quiet = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, pending_rsp.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit gap_search(int unsigned size, output int unsigned where);
    int unsigned cur;
    bit moved;
    cur = RSV;
    moved = 1;
    while (moved) begin
      moved = 0;
      if (cur + size > pool_end) return 0;
      for (int i = 1; i < SLOTS; i++) begin
        if (blk_valid[i] && cur < blk_off[i] + blk_size[i] && cur + size > blk_off[i]) begin
          cur = blk_off[i] + blk_size[i];
          moved = 1;
          break;
        end
      end
    end
    where = cur;
    return 1;
  endfunction

  function automatic void free_space(output int unsigned largest, output int unsigned total);
    int unsigned used, span, s, nxt;
    bit in_blk;
    used = 0;
    largest = 0;
    for (int i = 1; i < SLOTS; i++) if (blk_valid[i]) used += blk_size[i];
    span = pool_end > RSV ? pool_end - RSV : 0;
    total = span > used ? span - used : 0;
    for (int c = 0; c < SLOTS; c++) begin
      if (c == 0) s = RSV;
      else if (blk_valid[c]) s = blk_off[c] + blk_size[c];
      else continue;
      if (s < RSV || s >= pool_end) continue;
      nxt = pool_end;
      in_blk = 0;
      for (int i = 1; i < SLOTS; i++) begin
        if (!blk_valid[i]) continue;
        if (s >= blk_off[i] && s < blk_off[i] + blk_size[i]) begin
          in_blk = 1;
          break;
        end
        if (blk_off[i] >= s && blk_off[i] < nxt) nxt = blk_off[i];
      end
      if (!in_blk && nxt - s > largest) largest = nxt - s;
    end
  endfunction

  function automatic rsp_t xms_answer(logic [7:0] func, logic [15:0] dx, logic [15:0] bx);
    rsp_t r;
    int h;
    int unsigned where, lg, tt, nfree, lc, lin;
    bit ok;
    r = '0;
    ok = dx != 0 && dx < SLOTS && blk_valid[dx];
    case (func) inside
      FN_VERSION: begin
        r.ax = XMS_VERSION;
        r.bx = XMS_VERSION;
      end
      FN_HMA_REQ, FN_HMA_REL: r.err = ERR_NOHMA;
      [FN_A20_FIRST:FN_A20_LAST]: r.ax = AX_OK;
      FN_QUERY: begin
        free_space(lg, tt);
        r.ax = lg > 16'hFFFF ? 16'hFFFF : lg[15:0];
        r.dx = tt > 16'hFFFF ? 16'hFFFF : tt[15:0];
      end
      FN_ALLOC: begin
        h = -1;
        for (int i = 1; i < SLOTS; i++) if (!blk_valid[i]) begin
          h = i;
          break;
        end
        if (h < 0) r.err = ERR_NOHANDLE;
        else if (!gap_search(dx, where)) r.err = ERR_NOMEM;
        else begin
          blk_valid[h] = 1;
          blk_locks[h] = 0;
          blk_off[h] = where & 16'hFFFF;
          blk_size[h] = dx;
          r.ax = AX_OK;
          r.dx = 16'(h);
        end
      end
      FN_FREE: begin
        if (!ok) r.err = ERR_BADHANDLE;
        else if (blk_locks[dx] > 0) r.err = ERR_LOCKED;
        else begin
          blk_valid[dx] = 0;
          r.ax = AX_OK;
        end
      end
      FN_LOCK: begin
        if (!ok) r.err = ERR_BADHANDLE;
        else begin
          if (blk_locks[dx] < 16'hFFFF) blk_locks[dx]++;
          lin = LIN_BASE + (blk_off[dx] << 10);
          r.ax = AX_OK;
          r.dx = lin[31:16];
          r.bx = lin[15:0];
        end
      end
      FN_UNLOCK: begin
        if (!ok) r.err = ERR_BADHANDLE;
        else if (blk_locks[dx] == 0) r.err = ERR_NOTLOCKED;
        else begin
          blk_locks[dx]--;
          r.ax = AX_OK;
        end
      end
      FN_INFO: begin
        if (!ok) r.err = ERR_BADHANDLE;
        else begin
          nfree = 0;
          for (int i = 1; i < SLOTS; i++) if (!blk_valid[i]) nfree++;
          if (nfree > 255) nfree = 255;
          lc = blk_locks[dx] > 255 ? 255 : blk_locks[dx];
          r.ax = AX_OK;
          r.bx = {lc[7:0], nfree[7:0]};
          r.dx = 16'(blk_size[dx]);
        end
      end
      FN_REALLOC: begin
        if (!ok) r.err = ERR_BADHANDLE;
        else if (blk_locks[dx] > 0) r.err = ERR_LOCKED;
        else if (bx <= blk_size[dx]) begin
          blk_size[dx] = bx;
          r.ax = AX_OK;
        end else begin
          blk_valid[dx] = 0;
          if (!gap_search(bx, where)) r.err = ERR_NOMEM;
          else begin
            blk_off[dx] = where & 16'hFFFF;
            blk_size[dx] = bx;
            r.ax = AX_OK;
          end
          blk_valid[dx] = 1;
        end
      end
      FN_UMB_REQ: r.err = ERR_NOUMB;
      FN_UMB_REL: r.err = ERR_BADUMB;
      default: r.err = ERR_NOTIMPL;
    endcase
    return r;
  endfunction

  task automatic send_request(row_t row);
    rsp_t r;
    in_ch.valid <= 1;
    in_ch.func <= row.func;
    in_ch.dx_word <= row.dx;
    in_ch.bx_word <= row.bx;
    do @(posedge clk); while (!in_ch.ready);
    r = xms_answer(row.func, row.dx, row.bx);
    pending_rsp.push_back(row.typed ? row.rsp : r);
    beats_in++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic set_pool_end(logic [15:0] kb);
    in_ch.valid <= 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.pool_end_kb <= kb;
    do @(posedge clk); while (!cfg_ch.ready);
    pool_end = kb;
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic logic [15:0] pick_handle();
    int k;
    k = $urandom_range(0, 19);
    if (k < 16) return 16'($urandom_range(1, 12));
    if (k < 19) return 16'($urandom_range(0, 63));
    return 16'($urandom);
  endfunction

  function automatic row_t random_request(bit fill);
    row_t row;
    int k;
    row.typed = 0;
    row.rsp = '0;
    row.dx = pick_handle();
    row.bx = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
    k = fill ? $urandom_range(0, 9) : $urandom_range(0, 99);
    if (k < 8 || (fill && k < 9)) begin
      row.func = FN_ALLOC;
      row.dx = fill ? 16'($urandom_range(0, 20))
             : ($urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300)));
    end else if (fill) row.func = FN_QUERY;
    else if (k < 20) row.func = FN_ALLOC;
    else if (k < 30) row.func = FN_FREE;
    else if (k < 42) row.func = FN_LOCK;
    else if (k < 54) row.func = FN_UNLOCK;
    else if (k < 62) row.func = FN_INFO;
    else if (k < 76) row.func = FN_REALLOC;
    else if (k < 86) row.func = FN_QUERY;
    else if (k < 92) row.func = 8'($urandom_range(0, 17));
    else row.func = 8'($urandom);
    return row;
  endfunction

  function automatic row_t dir(logic [7:0] f, logic [15:0] d, logic [15:0] b, bit t,
                               logic [15:0] ax, logic [15:0] bxo, logic [15:0] dxo,
                               logic [3:0] e);
    row_t row;
    row.func = f;
    row.dx = d;
    row.bx = b;
    row.typed = t;
    row.rsp = '{ax, bxo, dxo, e};
    return row;
  endfunction

  initial begin
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1;
        repeat ($urandom_range(0, 7)) begin
          @(negedge clk);
          if (quiet) break;
        end
      end else begin
        out_ch.ready <= 0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_ax, out_ch.out_bx, out_ch.out_dx, out_ch.error_code};
      beats_out++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat ax=%h bx=%h dx=%h err=%0d",
                                       got.ax, got.bx, got.dx, got.err);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: want ax=%h bx=%h dx=%h err=%0d, got ax=%h bx=%h dx=%h err=%0d",
                     beats_out, want.ax, want.bx, want.dx, want.err,
                     got.ax, got.bx, got.dx, got.err);
        end
      end
    end
  end

  initial begin
    row_t table_rows[$];
    logic [15:0] pools[5];
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.dx_word = 0;
    in_ch.bx_word = 0;
    cfg_ch.valid = 0;
    cfg_ch.pool_end_kb = 0;
    out_ch.ready = 0;
    pool_end = POOL_END_RST;
    for (int i = 0; i < SLOTS; i++) begin
      blk_valid[i] = 0;
      blk_locks[i] = 0;
      blk_off[i] = 0;
      blk_size[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1;

    table_rows.push_back(dir(FN_VERSION, 16'hFFFF, 16'hFFFF, 1, XMS_VERSION, XMS_VERSION, 0,
                             ERR_NONE));
    table_rows.push_back(dir(FN_QUERY, 0, 0, 1, 32704, 0, 32704, ERR_NONE));
    table_rows.push_back(dir(FN_HMA_REQ, 0, 0, 1, 0, 0, 0, ERR_NOHMA));
    table_rows.push_back(dir(FN_HMA_REL, 0, 0, 1, 0, 0, 0, ERR_NOHMA));
    table_rows.push_back(dir(FN_A20_FIRST, 0, 0, 1, 1, 0, 0, ERR_NONE));
    table_rows.push_back(dir(FN_A20_LAST, 0, 0, 1, 1, 0, 0, ERR_NONE));
    table_rows.push_back(dir(FN_ALLOC, 0, 0, 1, 1, 0, 1, ERR_NONE));
    table_rows.push_back(dir(FN_ALLOC, 16'hFFFF, 0, 1, 0, 0, 0, ERR_NOMEM));
    table_rows.push_back(dir(FN_ALLOC, 100, 0, 1, 1, 0, 2, ERR_NONE));
    table_rows.push_back(dir(FN_LOCK, 0, 0, 1, 0, 0, 0, ERR_BADHANDLE));
    table_rows.push_back(dir(FN_LOCK, 64, 0, 1, 0, 0, 0, ERR_BADHANDLE));
    table_rows.push_back(dir(FN_LOCK, 2, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(dir(FN_INFO, 2, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(dir(FN_FREE, 2, 0, 1, 0, 0, 0, ERR_LOCKED));
    table_rows.push_back(dir(FN_REALLOC, 2, 500, 1, 0, 0, 0, ERR_LOCKED));
    table_rows.push_back(dir(FN_UNLOCK, 2, 0, 1, 1, 0, 0, ERR_NONE));
    table_rows.push_back(dir(FN_UNLOCK, 2, 0, 1, 0, 0, 0, ERR_NOTLOCKED));
    table_rows.push_back(dir(FN_REALLOC, 1, 300, 0, 0, 0, 0, 0));
    table_rows.push_back(dir(FN_REALLOC, 2, 16'hFFFF, 1, 0, 0, 0, ERR_NOMEM));
    table_rows.push_back(dir(FN_REALLOC, 2, 10, 1, 1, 0, 0, ERR_NONE));
    table_rows.push_back(dir(FN_QUERY, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(dir(FN_FREE, 2, 0, 1, 1, 0, 0, ERR_NONE));
    table_rows.push_back(dir(FN_INFO, 2, 0, 1, 0, 0, 0, ERR_BADHANDLE));
    table_rows.push_back(dir(FN_MOVE, 0, 0, 1, 0, 0, 0, ERR_NOTIMPL));
    table_rows.push_back(dir(FN_UMB_REQ, 0, 0, 1, 0, 0, 0, ERR_NOUMB));
    table_rows.push_back(dir(FN_UMB_REL, 0, 0, 1, 0, 0, 0, ERR_BADUMB));
    table_rows.push_back(dir(8'hFF, 0, 0, 1, 0, 0, 0, ERR_NOTIMPL));
    @(negedge clk);
    foreach (table_rows[i]) send_request(table_rows[i]);

    // fill the table to run out of handles, then shrink and regrow the pool under the blocks
    set_pool_end(16'hFFFF);
    repeat (72) send_request(random_request(1));
    pools = '{16'd64, 16'($urandom_range(100, 900)), 16'd2000, 16'hFFFF, POOL_END_RST};
    foreach (pools[p]) begin
      set_pool_end(pools[p]);
      if (p == 4) quiet = 1;
      repeat (8) send_request(random_request(0));
    end

    in_ch.valid <= 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("covered %0d requests over directed and random phases, %0d responses checked",
             beats_in, beats_out);
    $display("pool sizes visited: reset, 64, small, 2000, 65535; mismatches %0d", mismatches);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
